/* hw/rtl/ctip_pkg.sv */
// Shared types and constants for the character-cell terminal interpreter.
// Used by ctip_ctrl, ctip_datapath and the top level; depends on nothing.
package ctip_pkg;

  localparam int ROWS   = 10;
  localparam int COLS   = 10;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_AW = (COLS > 1) ? $clog2(COLS) : 1;

  // Cursor and coordinate fields are four bits wide on the ports.
  typedef logic [3:0] pos_t;
  typedef logic [7:0] char_t;
  typedef logic [COLS-1:0][7:0] row_t;

  // Operation codes.
  localparam logic [1:0] OP_STREAM = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_RESET  = 2'd2;

  // Parser phases.
  localparam logic [1:0] PH_NORMAL = 2'd0;
  localparam logic [1:0] PH_CARET  = 2'd1;
  localparam logic [1:0] PH_ROW    = 2'd2;

  // Characters with a meaning to the parser.
  localparam char_t CH_CARET = 8'h5E;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_NL    = 8'h0A;
  localparam char_t CH_0     = 8'h30;
  localparam char_t CH_9     = 8'h39;
  localparam char_t CH_R     = 8'h72;
  localparam char_t CH_L     = 8'h6C;
  localparam char_t CH_D     = 8'h64;
  localparam char_t CH_U     = 8'h75;
  localparam char_t CH_B     = 8'h62;
  localparam char_t CH_H     = 8'h68;
  localparam char_t CH_C     = 8'h63;
  localparam char_t CH_E     = 8'h65;
  localparam char_t CH_I     = 8'h69;
  localparam char_t CH_O     = 8'h6F;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // latch the transaction and read its screen row
    logic exec;   // interpret, write the row back and update the cursor
  } ctl_cmd_t;

endpackage

/* hw/rtl/ctip_ctrl.sv */
// Controller state machine of the terminal interpreter.
// Depends on ctip_pkg; drives the datapath through ctl_cmd_t.
module ctip_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  output ctip_pkg::ctl_cmd_t cmd
);
  import ctip_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WORK = 1'b1;

  logic state;
  logic state_next;
  logic accept;

  assign busy   = (state == ST_WORK);
  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_WORK;
      ST_WORK: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.load = accept;
    cmd.exec = (state == ST_WORK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.exec;
    end
  end

  // A result strobe always follows the work cycle.
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> done) else $error("result strobe missing after work cycle");
  a_done_only_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_WORK)) else $error("stray result strobe");
  a_work_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy) else $error("work phase longer than one cycle");

endmodule

/* hw/rtl/ctip_datapath.sv */
// Datapath of the terminal interpreter: row-wide screen memory, cursor,
// mode and parser registers. Depends on ctip_pkg; commanded by ctip_ctrl.
module ctip_datapath (
  input  logic               clk,
  input  logic               rst,
  input  ctip_pkg::ctl_cmd_t cmd,
  input  logic [1:0]         operation,
  input  logic [7:0]         stream_byte,
  input  logic [3:0]         read_row,
  input  logic [3:0]         read_col,
  output logic [7:0]         cell_char,
  output logic [3:0]         cursor_row,
  output logic [3:0]         cursor_col,
  output logic               insert_on
);
  import ctip_pkg::*;

  // Screen storage: one word per row; a cleared valid bit stands for a row of spaces.
  row_t            row_mem [ROWS];
  logic [ROWS-1:0] row_valid;

  // Transaction registers.
  logic [1:0] op_q;
  char_t      byte_q;
  pos_t       rcol_q;
  logic       read_ok_q;
  row_t       rd_row;
  logic       rd_valid;

  // Architectural state.
  pos_t       cur_row, cur_row_next;
  pos_t       cur_col, cur_col_next;
  logic       insert_mode, insert_mode_next;
  logic [1:0] phase, phase_next;
  pos_t       pending_row, pending_row_next;

  logic       read_ok;
  pos_t       rd_addr;
  row_t       row_in;
  row_t       row_new;
  logic       row_we;
  logic       clear_all;
  logic       put;
  logic       is_digit;
  pos_t       digit;
  char_t      cell_next;

  assign read_ok = (read_row < pos_t'(ROWS)) && (read_col < pos_t'(COLS));
  assign rd_addr = (operation == OP_READ && read_ok) ? read_row : cur_row;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= operation;
      byte_q    <= stream_byte;
      rcol_q    <= read_col;
      read_ok_q <= (operation == OP_READ) && read_ok;
      rd_row    <= row_mem[rd_addr[ROW_AW-1:0]];
      rd_valid  <= row_valid[rd_addr[ROW_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && row_we) begin
      row_mem[cur_row[ROW_AW-1:0]] <= row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.exec && clear_all) begin
      row_valid <= '0;
    end else if (cmd.exec && row_we) begin
      row_valid[cur_row[ROW_AW-1:0]] <= 1'b1;
    end
  end

  assign row_in   = rd_valid ? rd_row : {COLS{CH_SPACE}};
  assign is_digit = byte_q inside {[CH_0:CH_9]};
  assign digit    = byte_q[3:0];

  always_comb begin
    cur_row_next     = cur_row;
    cur_col_next     = cur_col;
    insert_mode_next = insert_mode;
    phase_next       = phase;
    pending_row_next = pending_row;
    row_new          = row_in;
    row_we           = 1'b0;
    clear_all        = 1'b0;
    put              = 1'b0;
    cell_next        = '0;

    case (op_q)
      OP_STREAM: begin
        if (byte_q == CH_NL) begin
          phase_next = PH_NORMAL;
        end else begin
          case (phase)
            PH_CARET: begin
              phase_next = PH_NORMAL;
              if (is_digit) begin
                pending_row_next = (digit > pos_t'(ROWS - 1)) ? pos_t'(ROWS - 1) : digit;
                phase_next       = PH_ROW;
              end else if (byte_q == CH_CARET) begin
                put = 1'b1;
              end else begin
                case (byte_q)
                  CH_R: if (cur_col < pos_t'(COLS - 1)) cur_col_next = cur_col + 4'd1;
                  CH_L: if (cur_col > 4'd0) cur_col_next = cur_col - 4'd1;
                  CH_D: if (cur_row < pos_t'(ROWS - 1)) cur_row_next = cur_row + 4'd1;
                  CH_U: if (cur_row > 4'd0) cur_row_next = cur_row - 4'd1;
                  CH_B: cur_col_next = '0;
                  CH_H: begin
                    cur_row_next = '0;
                    cur_col_next = '0;
                  end
                  CH_C: clear_all = 1'b1;
                  CH_E: begin
                    row_we = 1'b1;
                    for (int i = 0; i < COLS; i++) begin
                      if (pos_t'(i) >= cur_col) row_new[i] = CH_SPACE;
                    end
                  end
                  CH_I: insert_mode_next = 1'b1;
                  CH_O: insert_mode_next = 1'b0;
                  default: ;
                endcase
              end
            end
            PH_ROW: begin
              phase_next = PH_NORMAL;
              if (is_digit) begin
                cur_row_next = pending_row;
                cur_col_next = (digit > pos_t'(COLS - 1)) ? pos_t'(COLS - 1) : digit;
              end
            end
            default: begin
              if (byte_q == CH_CARET) phase_next = PH_CARET;
              else                    put        = 1'b1;
            end
          endcase
        end
      end
      OP_READ: begin
        if (read_ok_q) cell_next = row_in[rcol_q[COL_AW-1:0]];
      end
      OP_RESET: begin
        clear_all        = 1'b1;
        cur_row_next     = '0;
        cur_col_next     = '0;
        insert_mode_next = 1'b0;
        phase_next       = PH_NORMAL;
        pending_row_next = '0;
      end
      default: ;
    endcase

    if (put) begin
      row_we = 1'b1;
      if (insert_mode) begin
        for (int i = 1; i < COLS; i++) begin
          if (pos_t'(i) > cur_col) row_new[i] = row_in[i-1];
        end
      end
      row_new[cur_col[COL_AW-1:0]] = byte_q;
      if (cur_col < pos_t'(COLS - 1)) cur_col_next = cur_col + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row     <= '0;
      cur_col     <= '0;
      insert_mode <= 1'b0;
      phase       <= PH_NORMAL;
      pending_row <= '0;
      cell_char   <= '0;
    end else if (cmd.exec) begin
      cur_row     <= cur_row_next;
      cur_col     <= cur_col_next;
      insert_mode <= insert_mode_next;
      phase       <= phase_next;
      pending_row <= pending_row_next;
      cell_char   <= cell_next;
    end
  end

  assign cursor_row = cur_row;
  assign cursor_col = cur_col;
  assign insert_on  = insert_mode;

  // The cursor and a pending row never leave the screen.
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    cur_row < pos_t'(ROWS) && cur_col < pos_t'(COLS))
    else $error("cursor off screen");
  a_pending_on_screen: assert property (@(posedge clk) disable iff (rst)
    pending_row < pos_t'(ROWS)) else $error("pending row off screen");
  // Outside reset, the screen only changes in a work cycle.
  a_valid_stable: assert property (@(posedge clk) disable iff (rst)
    !$past(cmd.exec) |-> $stable(row_valid)) else $error("row valid bits moved");

endmodule

/* hw/rtl/char_terminal_control_interpreter.sv */
// Top level of the character-cell terminal interpreter.
// Depends on ctip_pkg, ctip_ctrl and ctip_datapath.
//
// Channel   Direction  Handshake      Payload
// command   in         start / busy   operation, stream_byte, read_row, read_col
// result    out        done strobe    cell_char, cursor_row, cursor_col, insert_on
//
// In each transaction the accepting edge reads the cursor's row (or the
// requested row) from the row-wide screen memory, and the work cycle then
// interprets the byte and writes the row back. A new command is not
// accepted while busy, so a transaction ends before the next one starts.
// The result is strobed by done for one cycle after the work cycle; the
// receiver cannot stall it, and a new command may be accepted in that cycle.
// Synchronous reset leaves the screen all spaces at once through per-row
// valid bits, with no clearing pass; the cursor goes home in overwrite mode.
module char_terminal_control_interpreter (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] operation,
  input  logic [7:0] stream_byte,
  input  logic [3:0] read_row,
  input  logic [3:0] read_col,
  output logic       done,
  output logic [7:0] cell_char,
  output logic [3:0] cursor_row,
  output logic [3:0] cursor_col,
  output logic       insert_on
);
  import ctip_pkg::*;

  // Commands from the controller to the datapath.
  ctl_cmd_t cmd;

  // The controller only sequences: accept, then the work cycle, then strobe.
  ctip_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // The datapath holds the screen, cursor, mode and the caret parser.
  ctip_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .operation   (operation),
    .stream_byte (stream_byte),
    .read_row    (read_row),
    .read_col    (read_col),
    .cell_char   (cell_char),
    .cursor_row  (cursor_row),
    .cursor_col  (cursor_col),
    .insert_on   (insert_on)
  );

endmodule
